[rtl/ufp_pkg.sv]
package ufp_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned MAX_RES   = 3;
	localparam int unsigned CNT_W     = 2;

	localparam logic [KIND_W-1:0] KIND_KEY  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_VAL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ERR  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECODE    = 1'd1;

	localparam logic [BYTE_W-1:0] SEPARATOR_RST = 8'h26;
	localparam logic              DECODE_RST    = 1'b1;

	localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
	localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_EQUAL   = 8'h3D;

	typedef struct packed {
		logic              command;
		logic [BYTE_W-1:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] out_byte;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic [CNT_W-1:0]            count;
		out_item_t [MAX_RES-1:0]     res;
	} ufp_batch_t;

endpackage

[rtl/ufp_core.sv]
module ufp_core import ufp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  in_item_t          in_data,
	input  logic [BYTE_W-1:0] separator,
	input  logic              decode_en,
	output logic              push,
	output ufp_batch_t        batch
);

	typedef enum logic [2:0] {
		ST_KEY    = 3'd0,
		ST_KEY_E1 = 3'd1,
		ST_KEY_E2 = 3'd2,
		ST_VAL    = 3'd3,
		ST_VAL_E1 = 3'd4,
		ST_VAL_E2 = 3'd5,
		ST_ERR    = 3'd6
	} state_t;

	typedef struct packed {
		logic              emit;
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] value;
		logic              set_st;
		state_t            st;
		logic              clr_khc;
	} plain_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] v;
	} hex_t;

	function automatic hex_t hex_dec(input logic [BYTE_W-1:0] c);
		hex_t h;
		h.ok = 1'b1;
		h.v  = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.v = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			h.v = c[3:0] + 4'd9;
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	function automatic plain_t plain_byte(input logic [BYTE_W-1:0] c, input logic in_value,
			input logic khc, input logic [BYTE_W-1:0] sep, input logic dec);
		plain_t p;
		p.emit    = 1'b0;
		p.kind    = in_value ? KIND_VAL : KIND_KEY;
		p.value   = c;
		p.set_st  = 1'b0;
		p.st      = ST_KEY;
		p.clr_khc = 1'b0;
		if (!in_value && c == CH_SPACE && !khc) begin
			p.emit = 1'b0;
		end else if (c == CH_PERCENT && dec) begin
			p.set_st = 1'b1;
			p.st     = in_value ? ST_VAL_E1 : ST_KEY_E1;
		end else if (c == CH_PLUS) begin
			p.emit  = 1'b1;
			p.value = CH_SPACE;
		end else if (c == sep) begin
			p.emit    = 1'b1;
			p.kind    = KIND_DONE;
			p.value   = '0;
			p.set_st  = 1'b1;
			p.st      = ST_KEY;
			p.clr_khc = 1'b1;
		end else if (!in_value && c == CH_EQUAL) begin
			p.set_st = 1'b1;
			p.st     = ST_VAL;
		end else begin
			p.emit = 1'b1;
		end
		return p;
	endfunction

	state_t            st_q, st_d;
	logic [3:0]        hn_q, hn_d;
	logic [BYTE_W-1:0] cand_q, cand_d;
	logic              khc_q, khc_d;

	logic              accept;
	logic              in_value;
	logic [KIND_W-1:0] bkind;
	state_t            base_st;
	hex_t              hx;
	plain_t            pb;
	logic              khc_arg;
	logic [BYTE_W-1:0] c;
	out_item_t [MAX_RES-1:0] res;
	logic [CNT_W-1:0]  n;
	logic [CNT_W-1:0]  last_idx;

	assign accept = in_valid && in_ready;
	assign c      = in_data.data_byte;

	always_comb begin
		in_value = (st_q == ST_VAL) || (st_q == ST_VAL_E1) || (st_q == ST_VAL_E2);
		bkind    = in_value ? KIND_VAL : KIND_KEY;
		base_st  = in_value ? ST_VAL : ST_KEY;
		hx       = hex_dec(c);
		khc_arg  = (st_q == ST_KEY_E2) ? 1'b1 : khc_q;
		pb       = plain_byte(c, in_value, khc_arg, separator, decode_en);

		st_d     = st_q;
		hn_d     = hn_q;
		cand_d   = cand_q;
		khc_d    = khc_q;
		res      = '0;
		n        = '0;
		last_idx = '0;

		if (in_data.command) begin
			res[0].kind = KIND_DONE;
			n = 2'd1;
			if (st_q != ST_ERR) begin
				st_d  = ST_KEY;
				khc_d = 1'b0;
			end
		end else if (st_q == ST_ERR) begin
			n = '0;
		end else if (c < CH_SPACE || c[BYTE_W-1]) begin
			st_d        = ST_ERR;
			res[0].kind = KIND_ERR;
			n = 2'd1;
		end else begin
			case (st_q)
				ST_KEY, ST_VAL: begin
					if (pb.emit) begin
						res[0].kind     = pb.kind;
						res[0].out_byte = pb.value;
						n = 2'd1;
						if (pb.kind == KIND_KEY) khc_d = 1'b1;
					end
					if (pb.set_st) st_d = pb.st;
					if (pb.clr_khc) khc_d = 1'b0;
				end
				ST_KEY_E1, ST_VAL_E1: begin
					if (hx.ok) begin
						hn_d   = hx.v;
						cand_d = c;
						st_d   = in_value ? ST_VAL_E2 : ST_KEY_E2;
					end else begin
						res[0].kind     = bkind;
						res[0].out_byte = CH_PERCENT;
						n = 2'd1;
						if (!in_value) khc_d = 1'b1;
						if (c != CH_PERCENT) begin
							res[1].kind     = bkind;
							res[1].out_byte = c;
							n    = 2'd2;
							st_d = base_st;
						end
					end
				end
				ST_KEY_E2, ST_VAL_E2: begin
					st_d = base_st;
					if (!in_value) khc_d = 1'b1;
					if (hx.ok) begin
						res[0].kind     = bkind;
						res[0].out_byte = {hn_q, hx.v};
						n      = 2'd1;
						cand_d = '0;
					end else begin
						res[0].kind     = bkind;
						res[0].out_byte = CH_PERCENT;
						res[1].kind     = bkind;
						res[1].out_byte = cand_q;
						n = 2'd2;
						if (pb.emit) begin
							res[2].kind     = pb.kind;
							res[2].out_byte = pb.value;
							n = 2'd3;
						end
						if (pb.set_st) st_d = pb.st;
						if (pb.clr_khc) khc_d = 1'b0;
					end
				end
				default: begin
					n = '0;
				end
			endcase
		end

		if (n != '0) begin
			last_idx = n - 2'd1;
			res[last_idx].last = 1'b1;
		end
	end

	assign push        = accept && (n != '0);
	assign batch.count = n;
	assign batch.res   = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_KEY;
			hn_q   <= '0;
			cand_q <= '0;
			khc_q  <= 1'b0;
		end else if (accept) begin
			st_q   <= st_d;
			hn_q   <= hn_d;
			cand_q <= cand_d;
			khc_q  <= khc_d;
		end
	end

endmodule

[rtl/ufp_outbuf.sv]
module ufp_outbuf import ufp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ufp_batch_t batch,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data
);

	out_item_t [MAX_RES-1:0] res_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        ptr_q;
	logic                    take;

	assign out_valid = (cnt_q != '0);
	assign out_data  = res_q[ptr_q];
	assign take      = out_valid && out_ready;
	assign in_ready  = (cnt_q == '0) || ((cnt_q == 2'd1) && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ptr_q <= '0;
		end else if (push) begin
			cnt_q <= batch.count;
			ptr_q <= '0;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
			ptr_q <= ptr_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= batch.res;
		end
	end

endmodule

[rtl/urlencoded_form_parser_top.sv]
// An input byte's first result is registered and offered in the cycle after the byte's beat.
// Throughput: one input beat per cycle while each byte yields at most one result and
// out_ready is high; a byte that yields several results (up to 3) holds the input until
// its last result is being taken, and a stalled output beat holds the input as well.
// Reset (arst_n low, asynchronous): parser returns to start of key, output buffer
// empties, separator resets to '&' and percent decoding is enabled.
module urlencoded_form_parser_top import ufp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data
);

	logic [BYTE_W-1:0] separator_q;
	logic              decode_q;
	logic              push;
	ufp_batch_t        batch;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			separator_q <= SEPARATOR_RST;
			decode_q    <= DECODE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SEPARATOR: separator_q <= cfg_data;
				CFG_DECODE:    decode_q    <= cfg_data[0];
				default: begin
					separator_q <= separator_q;
				end
			endcase
		end
	end

	ufp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.separator (separator_q),
		.decode_en (decode_q),
		.push      (push),
		.batch     (batch)
	);

	ufp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.batch     (batch),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
